### hw/rtl/artdmx_pkg.sv
// Shared constants and codes for the ArtDmx receiver with link failsafe.
package artdmx_pkg;

  // Universe size and datagram limits
  localparam int CHANNELS     = 512;
  localparam int MAX_DATAGRAM = 530;
  localparam int HDR_LEN      = 18;
  localparam int MAX_LEN      = 512;
  localparam int POS_MAX      = 1023;
  localparam int SIG_LEN      = 8;

  // Universe store: two entries per row, one per lane memory
  localparam int ROWS  = (CHANNELS + 1) / 2;
  localparam int ROW_W = 8;

  localparam int POS_W = 10;
  localparam int LEN_W = 16;
  localparam int CNT_W = 32;

  localparam logic [7:0] OPCODE_HI = 8'h50;
  localparam logic [7:0] OPCODE_LO = 8'h00;

  // Input commands
  localparam logic [1:0] CMD_BYTE      = 2'd0;
  localparam logic [1:0] CMD_LINK_DOWN = 2'd1;
  localparam logic [1:0] CMD_LINK_UP   = 2'd2;
  localparam logic [1:0] CMD_READ      = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_READ    = 2'd1;
  localparam logic [1:0] KIND_LINK    = 2'd2;

  // Verdict codes
  localparam logic [2:0] VD_ACCEPTED = 3'd0;
  localparam logic [2:0] VD_OVERSIZE = 3'd1;
  localparam logic [2:0] VD_BAD_SIG  = 3'd2;
  localparam logic [2:0] VD_BAD_OP   = 3'd3;
  localparam logic [2:0] VD_BAD_LEN  = 3'd4;
  localparam logic [2:0] VD_LINK_DN  = 3'd5;

  // Art-Net signature byte at a header position
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] v;
    unique case (idx)
      3'd0: v = 8'h41;
      3'd1: v = 8'h72;
      3'd2: v = 8'h74;
      3'd3: v = 8'h2D;
      3'd4: v = 8'h4E;
      3'd5: v = 8'h65;
      3'd6: v = 8'h74;
      3'd7: v = 8'h00;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/artdmx_receiver_with_failsafe_top.sv
// ArtDmx receiver top level: header parser, universe store and result pipeline.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  in_     | in  | in_valid/in_stall   | cmd, data_byte, last_byte, channel
//  out_    | out | out_valid/out_stall | kind, verdict, packet_count, channel_value,
//          |     |                    | blackout
//
// One beat is taken per cycle while in_stall is low. A result passes through the read
// stage, which holds the registered read of the universe store, then the output register.
// Reset clears the parser, the link flag, the packet count and all row valid flags
// at once; no clearing pass over the store is needed.
// in_stall rises only when the read stage and the output register both hold a
// result and out_stall is high.
module artdmx_receiver_with_failsafe_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [8:0]  in_channel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_verdict,
  output logic [31:0] out_packet_count,
  output logic [7:0]  out_channel_value,
  output logic        out_blackout
);

  localparam int PW = artdmx_pkg::POS_W;
  localparam int LW = artdmx_pkg::LEN_W;
  localparam int CW = artdmx_pkg::CNT_W;
  localparam int RW = artdmx_pkg::ROW_W;

  // ---------------------------------------------------------------------------
  // Parser and link state
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pos_r, pos_nxt;
  logic          sig_ok_r, sig_ok_nxt;
  logic [7:0]    op_lo_r, op_lo_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          link_lost_r, link_lost_nxt;
  logic [CW-1:0] acc_cnt_r, acc_cnt_nxt;

  // Row valid flags: one per pair of channels, cleared at once on blackout
  logic [artdmx_pkg::ROWS-1:0] row_vld_r;

  // Universe store, even and odd channels; each word is {entry valid, level}
  logic [8:0] mem_lo [artdmx_pkg::ROWS];
  logic [8:0] mem_hi [artdmx_pkg::ROWS];
  logic [8:0] rd_lo_r, rd_hi_r;

  // Read stage (store data lands here)
  logic          s1_v_r, s1_v_nxt;
  logic [1:0]    s1_kind_r, s1_kind_nxt;
  logic [2:0]    s1_verdict_r, s1_verdict_nxt;
  logic [CW-1:0] s1_count_r;
  logic          s1_blk_r, s1_blk_nxt;
  logic          s1_rd_r, s1_ok_r, s1_lane_r;

  // Output register
  logic          out_valid_r;
  logic [1:0]    out_kind_r;
  logic [2:0]    out_verdict_r;
  logic [CW-1:0] out_count_r;
  logic [7:0]    out_value_r;
  logic          out_blk_r;

  logic acc;
  logic adv;
  logic blackout_c;

  // Store write controls
  logic          wr_en;
  logic [PW-1:0] wr_d;
  logic [RW-1:0] wr_row;
  logic          wr_lane;
  logic          wr_fresh;

  logic [RW-1:0] rd_row;
  logic [8:0]    s1_word;

  logic [PW-1:0] cnt_c;
  logic          hdr_ok_c;
  logic          byte_live;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = s1_v_r && out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;
  assign rd_row   = in_channel[RW:1];

  always_comb begin
    pos_nxt        = pos_r;
    sig_ok_nxt     = sig_ok_r;
    op_lo_nxt      = op_lo_r;
    len_nxt        = len_r;
    link_lost_nxt  = link_lost_r;
    acc_cnt_nxt    = acc_cnt_r;
    s1_v_nxt       = 1'b0;
    s1_kind_nxt    = artdmx_pkg::KIND_VERDICT;
    s1_verdict_nxt = artdmx_pkg::VD_ACCEPTED;
    s1_blk_nxt     = 1'b0;
    blackout_c     = 1'b0;
    wr_en          = 1'b0;
    wr_d           = '0;
    cnt_c          = '0;
    hdr_ok_c       = 1'b0;
    byte_live      = 1'b0;

    if (acc) begin
      unique case (in_cmd)
        artdmx_pkg::CMD_LINK_DOWN: begin
          if (!link_lost_r) begin
            blackout_c = 1'b1;
            s1_blk_nxt = 1'b1;
          end
          link_lost_nxt  = 1'b1;
          pos_nxt        = '0;
          sig_ok_nxt     = 1'b1;
          op_lo_nxt      = '0;
          len_nxt        = '0;
          s1_v_nxt       = 1'b1;
          s1_kind_nxt    = artdmx_pkg::KIND_LINK;
          s1_verdict_nxt = artdmx_pkg::VD_LINK_DN;
        end
        artdmx_pkg::CMD_LINK_UP: begin
          link_lost_nxt = 1'b0;
          pos_nxt       = '0;
          sig_ok_nxt    = 1'b1;
          op_lo_nxt     = '0;
          len_nxt       = '0;
          s1_v_nxt      = 1'b1;
          s1_kind_nxt   = artdmx_pkg::KIND_LINK;
        end
        artdmx_pkg::CMD_READ: begin
          s1_v_nxt    = 1'b1;
          s1_kind_nxt = artdmx_pkg::KIND_READ;
        end
        artdmx_pkg::CMD_BYTE: begin
          if (link_lost_r) begin
            // ignored until link-up; only the last mark answers
            s1_v_nxt       = in_last_byte;
            s1_verdict_nxt = artdmx_pkg::VD_LINK_DN;
          end else begin
            byte_live = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (byte_live) begin
      // header fields
      if (pos_r < PW'(artdmx_pkg::SIG_LEN)) begin
        if (in_data_byte != artdmx_pkg::sig_byte(pos_r[2:0])) sig_ok_nxt = 1'b0;
      end else if (pos_r == PW'(8)) begin
        op_lo_nxt = in_data_byte;
      end else if (pos_r == PW'(9)) begin
        if (in_data_byte != artdmx_pkg::OPCODE_HI) op_lo_nxt = 8'hFF;
      end else if (pos_r == PW'(16)) begin
        len_nxt = {in_data_byte, 8'h00};
      end else if (pos_r == PW'(17)) begin
        len_nxt = {len_r[LW-1:8], in_data_byte};
      end else if (pos_r >= PW'(artdmx_pkg::HDR_LEN) &&
                   pos_r < PW'(artdmx_pkg::MAX_DATAGRAM) &&
                   sig_ok_r && op_lo_r == artdmx_pkg::OPCODE_LO &&
                   len_r >= LW'(1) && len_r <= LW'(artdmx_pkg::MAX_LEN)) begin
        wr_d = pos_r - PW'(artdmx_pkg::HDR_LEN);
        if (LW'(wr_d) < len_r && wr_d < PW'(artdmx_pkg::CHANNELS)) wr_en = 1'b1;
      end

      cnt_c   = (pos_r < PW'(artdmx_pkg::POS_MAX)) ? pos_r + PW'(1) : pos_r;
      pos_nxt = cnt_c;

      if (in_last_byte) begin
        hdr_ok_c = cnt_c >= PW'(artdmx_pkg::HDR_LEN) && len_nxt >= LW'(1) &&
                   len_nxt <= LW'(artdmx_pkg::MAX_LEN);
        s1_v_nxt = 1'b1;
        priority if (cnt_c > PW'(artdmx_pkg::MAX_DATAGRAM)) begin
          s1_verdict_nxt = artdmx_pkg::VD_OVERSIZE;
        end else if (cnt_c < PW'(8) || !sig_ok_nxt) begin
          s1_verdict_nxt = artdmx_pkg::VD_BAD_SIG;
        end else if (cnt_c < PW'(10) || op_lo_nxt != artdmx_pkg::OPCODE_LO) begin
          s1_verdict_nxt = artdmx_pkg::VD_BAD_OP;
        end else if (!hdr_ok_c) begin
          s1_verdict_nxt = artdmx_pkg::VD_BAD_LEN;
        end else begin
          s1_verdict_nxt = artdmx_pkg::VD_ACCEPTED;
          acc_cnt_nxt    = acc_cnt_r + CW'(1);
        end
        pos_nxt    = '0;
        sig_ok_nxt = 1'b1;
        op_lo_nxt  = '0;
        len_nxt    = '0;
      end
    end
  end

  assign wr_row   = wr_d[RW:1];
  assign wr_lane  = wr_d[0];
  assign wr_fresh = !row_vld_r[wr_row];

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      sig_ok_r    <= 1'b1;
      op_lo_r     <= '0;
      len_r       <= '0;
      link_lost_r <= 1'b0;
      acc_cnt_r   <= '0;
      row_vld_r   <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      sig_ok_r    <= sig_ok_nxt;
      op_lo_r     <= op_lo_nxt;
      len_r       <= len_nxt;
      link_lost_r <= link_lost_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      if (blackout_c) begin
        row_vld_r <= '0;
      end else if (wr_en) begin
        row_vld_r[wr_row] <= 1'b1;
      end
      if (acc) begin
        s1_v_r <= s1_v_nxt;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= s1_v_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Universe store: one write per data byte; a fresh row also marks its
  // other entry empty so stale contents never read back
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (!wr_lane) begin
        mem_lo[wr_row] <= {1'b1, in_data_byte};
      end else if (wr_fresh) begin
        mem_lo[wr_row] <= 9'h000;
      end
      if (wr_lane) begin
        mem_hi[wr_row] <= {1'b1, in_data_byte};
      end else if (wr_fresh) begin
        mem_hi[wr_row] <= 9'h000;
      end
    end
    if (acc && in_cmd == artdmx_pkg::CMD_READ) begin
      rd_lo_r <= mem_lo[rd_row];
      rd_hi_r <= mem_hi[rd_row];
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage and output register payload
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_kind_r    <= s1_kind_nxt;
      s1_verdict_r <= s1_verdict_nxt;
      s1_count_r   <= acc_cnt_nxt;
      s1_blk_r     <= s1_blk_nxt;
      s1_rd_r      <= in_cmd == artdmx_pkg::CMD_READ;
      s1_ok_r      <= row_vld_r[rd_row] &&
                      (PW'(in_channel) < PW'(artdmx_pkg::CHANNELS));
      s1_lane_r    <= in_channel[0];
    end
    if (adv && s1_v_r) begin
      out_kind_r    <= s1_kind_r;
      out_verdict_r <= s1_verdict_r;
      out_count_r   <= s1_count_r;
      out_blk_r     <= s1_blk_r;
      out_value_r   <= (s1_rd_r && s1_ok_r && s1_word[8]) ? s1_word[7:0] : 8'h00;
    end
  end

  assign s1_word = s1_lane_r ? rd_hi_r : rd_lo_r;

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_verdict       = out_verdict_r;
  assign out_packet_count  = out_count_r;
  assign out_channel_value = out_value_r;
  assign out_blackout      = out_blk_r;

endmodule
